// ===== rtl/spe_pkg.sv =====
// Shared types, codes and key mapping for the step sequencer pattern editor.
// No dependencies; imported by the interfaces, spe_edit_core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package spe_pkg;

  localparam int STEP_COUNT_DEF  = 16;
  localparam int VOICE_COUNT_DEF = 6;
  localparam int PAD_W           = 6;   // pad level / lamp field width
  localparam int STEP_OUT_W      = 4;   // step_index field width

  typedef enum logic [2:0] {
    KEY_NONE  = 3'd0,
    KEY_A_LOW = 3'd1,
    KEY_A_UP  = 3'd2,
    KEY_HASH  = 3'd3,
    KEY_C     = 3'd4,
    KEY_B_LOW = 3'd5,
    KEY_B_UP  = 3'd6
  } key_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_HOLD    = 2'd1,
    EV_RELEASE = 2'd2
  } kev_t;

  typedef enum logic {
    CMD_KEY = 1'b0,
    CMD_PAD = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    POS_A    = 2'd0,
    POS_HASH = 2'd1,
    POS_C    = 2'd2,
    POS_B    = 2'd3
  } kpos_t;

  typedef struct packed {
    logic             command;
    logic [1:0]       key_position;
    logic [1:0]       key_event;
    logic [PAD_W-1:0] pad_levels;
  } in_item_t;

  typedef struct packed {
    logic [STEP_OUT_W-1:0] step_index;
    logic [1:0]            sequence_mode;
    logic                  playing;
    logic                  shifted;
    logic [PAD_W-1:0]      lamps;
    logic [2:0]            returned_key;
    logic                  blink_request;
  } res_item_t;

  // base keymap: a, hash, c, b; shifted keymap: A, hash, c, B
  function automatic key_t map_key(input logic [1:0] pos, input logic shift);
    key_t k;
    case (pos)
      POS_A:    k = shift ? KEY_A_UP : KEY_A_LOW;
      POS_HASH: k = KEY_HASH;
      POS_C:    k = KEY_C;
      POS_B:    k = shift ? KEY_B_UP : KEY_B_LOW;
      default:  k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/spe_in_if.sv =====
// Input channel of the pattern editor: valid/ready plus one key or pad item.
// Depends on spe_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface spe_in_if;
  import spe_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [1:0]       key_position;
  logic [1:0]       key_event;
  logic [PAD_W-1:0] pad_levels;

  modport source (output valid, command, key_position, key_event, pad_levels,
                  input ready);
  modport sink   (input valid, command, key_position, key_event, pad_levels,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/spe_out_if.sv =====
// Result channel of the pattern editor: valid/ready plus one status item.
// Depends on spe_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spe_out_if;
  import spe_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STEP_OUT_W-1:0] step_index;
  logic [1:0]            sequence_mode;
  logic                  playing;
  logic                  shifted;
  logic [PAD_W-1:0]      lamps;
  logic [2:0]            returned_key;
  logic                  blink_request;

  modport source (output valid, step_index, sequence_mode, playing, shifted, lamps,
                         returned_key, blink_request,
                  input ready);
  modport sink   (input valid, step_index, sequence_mode, playing, shifted, lamps,
                        returned_key, blink_request,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/spe_edit_core.sv =====
// Editor state (step, mode, play, shift, pad latches, pattern store) and the
// per-item next-state logic. Depends on spe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spe_edit_core #(
  parameter int STEP_COUNT  = spe_pkg::STEP_COUNT_DEF,
  parameter int VOICE_COUNT = spe_pkg::VOICE_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               commit,   // item moves to the result register
  input  wire spe_pkg::in_item_t  item,
  output spe_pkg::res_item_t      res
);
  import spe_pkg::*;

  localparam int SW = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
  localparam logic [SW-1:0] STEP_LAST = SW'(STEP_COUNT - 1);

  logic [SW-1:0]          step_r, step_nxt;
  logic [1:0]             mode_r, mode_nxt;
  logic                   play_r, play_nxt;
  logic                   shift_r, shift_nxt;
  logic [VOICE_COUNT-1:0] held_r, held_nxt;
  logic [VOICE_COUNT-1:0] latch_r, latch_nxt;
  logic [VOICE_COUNT-1:0] pat_r [STEP_COUNT];

  logic [VOICE_COUNT-1:0] pressed, new_press, col_rd, col_nxt, lamp_v;
  logic                   pad_cmd;
  key_t                   key;
  logic [2:0]             ret_key;
  logic                   blink;

  always_comb begin
    pad_cmd   = (item.command == CMD_PAD);
    key       = map_key(item.key_position, shift_r);
    step_nxt  = step_r;
    mode_nxt  = mode_r;
    play_nxt  = play_r;
    shift_nxt = shift_r;
    ret_key   = KEY_NONE;
    blink     = 1'b0;

    if (!pad_cmd) begin
      if (item.key_event == EV_PRESS) begin
        ret_key = key;
        case (key)
          KEY_A_LOW: step_nxt = (step_r == STEP_LAST) ? '0 : step_r + 1'b1;
          KEY_B_LOW: step_nxt = (step_r == '0) ? STEP_LAST : step_r - 1'b1;
          KEY_B_UP:  mode_nxt = mode_r + 2'd1;
          KEY_C:     play_nxt = !play_r;
          default:   ;
        endcase
      end else if (item.key_event == EV_HOLD && key == KEY_HASH) begin
        shift_nxt = !shift_r;
        blink     = 1'b1;
      end
    end

    // voices past the pad field read as pressed
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (i < PAD_W) pressed[i] = !item.pad_levels[i];
      else           pressed[i] = 1'b1;
    end
    new_press = pressed & ~held_r;

    // a pad item never moves the step, so one read at step_nxt serves both
    col_rd = pat_r[step_nxt];
    if (pad_cmd) begin
      held_nxt  = pressed;
      latch_nxt = shift_r ? latch_r : (latch_r ^ new_press);
      col_nxt   = (col_rd & ~new_press) | (latch_nxt & new_press);
    end else begin
      held_nxt  = held_r;
      latch_nxt = latch_r;
      col_nxt   = col_rd;
    end

    lamp_v = shift_nxt ? held_nxt : col_nxt;

    res.step_index    = STEP_OUT_W'(step_nxt);
    res.sequence_mode = mode_nxt;
    res.playing       = play_nxt;
    res.shifted       = shift_nxt;
    res.lamps         = PAD_W'(lamp_v);
    res.returned_key  = ret_key;
    res.blink_request = blink;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      mode_r  <= '0;
      play_r  <= 1'b0;
      shift_r <= 1'b0;
      held_r  <= '0;
      latch_r <= '0;
      for (int s = 0; s < STEP_COUNT; s++) pat_r[s] <= '0;
    end else if (commit) begin
      step_r  <= step_nxt;
      mode_r  <= mode_nxt;
      play_r  <= play_nxt;
      shift_r <= shift_nxt;
      held_r  <= held_nxt;
      latch_r <= latch_nxt;
      if (pad_cmd) pat_r[step_r] <= col_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/step_sequencer_pattern_editor.sv =====
// Top level of the step sequencer pattern editor: input register, edit core
// and result register. Depends on spe_pkg, spe_in_if, spe_out_if, spe_edit_core.
//
//   channel  | dir | handshake      | carries
//   ---------+-----+----------------+---------------------------------------------
//   in_ch    | in  | valid / ready  | command, key_position, key_event, pad_levels
//   out_ch   | out | valid / ready  | step, mode, play, shift, lamps, key, blink
//
// One item per cycle sustained while out_ch is ready; an accepted item goes to the
// input register, then its result, from the single editor pass, to the result register.
// Synchronous active-low reset clears the state and the pattern store at once.
// The input register takes a new item whenever its item moves on or it is empty,
// so the input stalls only while both registers hold items and the result waits.
`timescale 1ns / 1ps
`default_nettype none

module step_sequencer_pattern_editor #(
  parameter int STEP_COUNT  = spe_pkg::STEP_COUNT_DEF,
  parameter int VOICE_COUNT = spe_pkg::VOICE_COUNT_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  spe_in_if.sink     in_ch,
  spe_out_if.source  out_ch
);
  import spe_pkg::*;

  logic      s1_v_r, s1_v_nxt;
  in_item_t  s1_r;
  logic      out_v_r, out_v_nxt;
  res_item_t out_r;
  res_item_t res;
  logic      s1_go, in_take;

  assign s1_go   = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_v_r || s1_go;

  assign s1_v_nxt  = in_take || (s1_v_r && !s1_go);
  assign out_v_nxt = s1_go || (out_v_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r.command      <= in_ch.command;
      s1_r.key_position <= in_ch.key_position;
      s1_r.key_event    <= in_ch.key_event;
      s1_r.pad_levels   <= in_ch.pad_levels;
    end
    if (s1_go) out_r <= res;
  end

  spe_edit_core #(
    .STEP_COUNT  (STEP_COUNT),
    .VOICE_COUNT (VOICE_COUNT)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (s1_go),
    .item   (s1_r),
    .res    (res)
  );

  assign out_ch.valid         = out_v_r;
  assign out_ch.step_index    = out_r.step_index;
  assign out_ch.sequence_mode = out_r.sequence_mode;
  assign out_ch.playing       = out_r.playing;
  assign out_ch.shifted       = out_r.shifted;
  assign out_ch.lamps         = out_r.lamps;
  assign out_ch.returned_key  = out_r.returned_key;
  assign out_ch.blink_request = out_r.blink_request;

  // a stalled input register keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_go |=> s1_v_r)
    else $error("input register dropped a stalled item");

  // an empty result register never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ch.ready)
    else $error("input stalled with result register empty");

  // a blink comes only from a hold, which reports no key
  a_blink_nokey: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.blink_request |-> out_r.returned_key == KEY_NONE)
    else $error("blink request together with a returned key");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for step_sequencer_pattern_editor: directed and random key/pad items,
// predicted per item by a scoreboard class. Needs spe_pkg, spe_in_if, spe_out_if and the RTL.
`timescale 1ns / 1ps

module testbench;
  import spe_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD = 80;
  localparam int RANDOM_ITEMS = 1900;
  localparam logic [1:0] EV_UNKNOWN = 2'd3;

  // Tracks the editor state and holds the status items it should return.
  class edit_scoreboard;
    res_item_t status_q[$];
    int step;
    int mode;
    bit play;
    bit shift;
    logic [PAD_W-1:0] held;
    logic [PAD_W-1:0] latch;
    logic [PAD_W-1:0] pattern [STEP_COUNT_DEF];
    int mismatches;

    function new();
      step = 0;
      mode = 0;
      play = 0;
      shift = 0;
      held = '0;
      latch = '0;
      foreach (pattern[i]) pattern[i] = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void note_item(in_item_t it);
      key_t base_keys [4];
      key_t shift_keys [4];
      key_t k;
      key_t ret;
      bit blink;
      bit down;
      res_item_t r;
      base_keys = '{KEY_A_LOW, KEY_HASH, KEY_C, KEY_B_LOW};
      shift_keys = '{KEY_A_UP, KEY_HASH, KEY_C, KEY_B_UP};
      ret = KEY_NONE;
      blink = 0;
      if (it.command == CMD_KEY) begin
        k = shift ? shift_keys[it.key_position] : base_keys[it.key_position];
        if (it.key_event == EV_PRESS) begin
          case (k)
            KEY_A_LOW: step = (step + 1 >= STEP_COUNT_DEF) ? 0 : step + 1;
            KEY_B_LOW: step = (step == 0) ? STEP_COUNT_DEF - 1 : step - 1;
            KEY_B_UP:  mode = (mode + 1) & 3;
            KEY_C:     play = !play;
            default: ;
          endcase
          ret = k;
        end else if (it.key_event == EV_HOLD && k == KEY_HASH) begin
          shift = !shift;
          blink = 1;
        end
      end else begin
        for (int i = 0; i < VOICE_COUNT_DEF; i++) begin
          down = (it.pad_levels[i] == 1'b0);
          if (down && !held[i]) begin
            held[i] = 1'b1;
            if (!shift) latch[i] = !latch[i];
            pattern[step][i] = latch[i];
          end else if (!down) begin
            held[i] = 1'b0;
          end
        end
      end
      r.step_index = step[STEP_OUT_W-1:0];
      r.sequence_mode = mode[1:0];
      r.playing = play;
      r.shifted = shift;
      r.lamps = shift ? held : pattern[step];
      r.returned_key = ret;
      r.blink_request = blink;
      status_q.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in %s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item with none expected");
        return;
      end
      want = status_q.pop_front();
      check_field("step_index", want.step_index, got.step_index);
      check_field("sequence_mode", want.sequence_mode, got.sequence_mode);
      check_field("playing", want.playing, got.playing);
      check_field("shifted", want.shifted, got.shifted);
      check_field("lamps", want.lamps, got.lamps);
      check_field("returned_key", want.returned_key, got.returned_key);
      check_field("blink_request", want.blink_request, got.blink_request);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic long_hold_req = 1'b0;
  bit tx_idle_en;
  bit rx_idle_en;
  int cycles;
  logic [PAD_W-1:0] last_levels;
  edit_scoreboard sb;

  spe_in_if in_ch();
  spe_out_if out_ch();

  step_sequencer_pattern_editor u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both handshakes sampled at the edge, before any driven change lands.
  always @(posedge clk) begin
    res_item_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_item('{in_ch.command, in_ch.key_position, in_ch.key_event,
                       in_ch.pad_levels});
      end
      if (out_ch.valid && out_ch.ready) begin
        got.step_index = out_ch.step_index;
        got.sequence_mode = out_ch.sequence_mode;
        got.playing = out_ch.playing;
        got.shifted = out_ch.shifted;
        got.lamps = out_ch.lamps;
        got.returned_key = out_ch.returned_key;
        got.blink_request = out_ch.blink_request;
        sb.check_result(got);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[step_sequencer_pattern_editor] ERROR");
    $finish;
  end

  // Result side: random stall bursts plus one long hold on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t key_item(logic [1:0] pos, logic [1:0] ev);
    in_item_t it;
    it.command = CMD_KEY;
    it.key_position = pos;
    it.key_event = ev;
    it.pad_levels = PAD_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t pad_item(logic [PAD_W-1:0] levels);
    in_item_t it;
    it.command = CMD_PAD;
    it.key_position = 2'($urandom);
    it.key_event = 2'($urandom);
    it.pad_levels = levels;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.command <= it.command;
    in_ch.key_position <= it.key_position;
    in_ch.key_event <= it.key_event;
    in_ch.pad_levels <= it.pad_levels;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic idle_for(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_gapped(input in_item_t it);
    if (tx_idle_en && $urandom_range(0, 5) == 0) idle_for($urandom_range(1, 14));
    send_item(it);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pad items (mostly press/release walks, some random and extreme scans) or key items, half each.
  function automatic in_item_t random_item();
    int r;
    logic [1:0] ev;
    logic [1:0] pos;
    if ($urandom_range(0, 1) == 0) begin
      r = $urandom_range(0, 9);
      if (r < 6) last_levels[$urandom_range(0, PAD_W - 1)] ^= 1'b1;
      else if (r < 8) last_levels = PAD_W'($urandom);
      else if (r == 8) last_levels = '1;
      else last_levels = '0;
      return pad_item(last_levels);
    end
    pos = 2'($urandom);
    r = $urandom_range(0, 9);
    if (r < 5) ev = EV_PRESS;
    else if (r < 7) begin
      ev = EV_HOLD;
      if ($urandom_range(0, 1) == 0) pos = POS_HASH;
    end else if (r < 9) ev = EV_RELEASE;
    else ev = EV_UNKNOWN;
    return key_item(pos, ev);
  endfunction

  initial begin
    sb = new();
    last_levels = '1;
    tx_idle_en = 1;
    rx_idle_en = 1;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= 1'b0;
    in_ch.key_position <= 2'd0;
    in_ch.key_event <= 2'd0;
    in_ch.pad_levels <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // step wrap both ways, play, hash press, ignored events
    send_gapped(key_item(POS_A, EV_PRESS));
    send_gapped(key_item(POS_B, EV_PRESS));
    send_gapped(key_item(POS_B, EV_PRESS));
    send_gapped(key_item(POS_A, EV_PRESS));
    send_gapped(key_item(POS_C, EV_PRESS));
    send_gapped(key_item(POS_HASH, EV_PRESS));
    send_gapped(key_item(POS_A, EV_HOLD));
    send_gapped(key_item(POS_C, EV_RELEASE));
    send_gapped(key_item(POS_B, EV_UNKNOWN));
    // pads: all pressed, all released, a mix
    send_gapped(pad_item('0));
    send_gapped(pad_item('1));
    send_gapped(pad_item(6'h2A));
    // shifted keymap: held pads on lamps, A and B, mode wrap
    send_gapped(key_item(POS_HASH, EV_HOLD));
    send_gapped(pad_item(6'h3E));
    send_gapped(key_item(POS_A, EV_PRESS));
    repeat (4) send_gapped(key_item(POS_B, EV_PRESS));
    send_gapped(key_item(POS_C, EV_PRESS));
    send_gapped(key_item(POS_HASH, EV_HOLD));
    send_gapped(pad_item('1));
    send_gapped(key_item(POS_C, EV_PRESS));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      if (n == 400) begin
        // receiver holds off while items keep coming; the input must stall
        tx_idle_en = 0;
        long_hold_req <= 1'b1;
      end
      if (n == 800) wait_drained();
      if (n >= RANDOM_ITEMS - 300) begin
        tx_idle_en = 0;
        rx_idle_en = 0;
      end
      send_gapped(random_item());
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[step_sequencer_pattern_editor] OK");
    end else begin
      $display("[step_sequencer_pattern_editor] ERROR");
    end
    $finish;
  end

endmodule

// ===== step_sequencer_pattern_editor.f =====
rtl/spe_pkg.sv
rtl/spe_in_if.sv
rtl/spe_out_if.sv
rtl/spe_edit_core.sv
rtl/step_sequencer_pattern_editor.sv
test/testbench.sv
